/* hw/rtl/lpms_pkg.sv */
// Package for the LED pattern mode sequencer: widths, reset values, mode and
// register index codes, shared structs and the xorshift32 step function.
// No dependencies.
`timescale 1ns / 1ps

package lpms_pkg;

  // Field and register widths
  localparam int unsigned HoldWidthDef = 24;
  localparam int unsigned CfgW         = 24;
  localparam int unsigned SeedW        = 32;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 32;
  localparam int unsigned LedW         = 4;
  localparam int unsigned ModeW        = 2;
  localparam int unsigned BouncePosW   = 2;
  localparam int unsigned CountW       = 4;

  // Register reset values
  localparam logic [CfgW-1:0]  BounceHoldRst  = CfgW'(90000);
  localparam logic [CfgW-1:0]  CountHoldRst   = CfgW'(120000);
  localparam logic [CfgW-1:0]  BreathPeriodRst = CfgW'(200000);
  localparam logic [CfgW-1:0]  BreathIncRst   = CfgW'(5000);
  localparam logic [CfgW-1:0]  RandomHoldRst  = CfgW'(80000);
  localparam logic [CfgW-1:0]  DebounceRst    = CfgW'(60000);
  localparam logic [SeedW-1:0] SeedRst        = 32'h1234_5678;

  // Xorshift32 shift amounts
  localparam int unsigned XsShiftA = 13;
  localparam int unsigned XsShiftB = 17;
  localparam int unsigned XsShiftC = 5;

  typedef enum logic [ModeW-1:0] {
    MODE_BOUNCE = 2'd0,
    MODE_COUNT  = 2'd1,
    MODE_BREATH = 2'd2,
    MODE_RANDOM = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_BOUNCE_HOLD   = 3'd0,
    REG_COUNT_HOLD    = 3'd1,
    REG_BREATH_PERIOD = 3'd2,
    REG_BREATH_INC    = 3'd3,
    REG_RANDOM_HOLD   = 3'd4,
    REG_DEBOUNCE_WAIT = 3'd5,
    REG_RANDOM_SEED   = 3'd6
  } reg_idx_e;

  // Timing registers seen by the step logic
  typedef struct packed {
    logic [CfgW-1:0] bounce_hold;
    logic [CfgW-1:0] count_hold;
    logic [CfgW-1:0] breath_period;
    logic [CfgW-1:0] breath_inc;
    logic [CfgW-1:0] random_hold;
  } cfg_t;

  // Seed write: load the xorshift state at once
  typedef struct packed {
    logic             load;
    logic [SeedW-1:0] seed;
  } seed_load_t;

  // Fixed-width part of one result word
  typedef struct packed {
    logic [LedW-1:0] leds;
    mode_e           mode;
    logic            press_accepted;
  } step_t;

  function automatic logic [SeedW-1:0] xorshift32(input logic [SeedW-1:0] x);
    logic [SeedW-1:0] a;
    logic [SeedW-1:0] b;
    a = x ^ (x << XsShiftA);
    b = a ^ (a >> XsShiftB);
    return b ^ (b << XsShiftC);
  endfunction

endpackage

/* hw/rtl/lpms_if.sv */
// Handshake interfaces of the LED pattern mode sequencer: step input,
// result output and configuration write channel. Depends on lpms_pkg.
`timescale 1ns / 1ps

interface lpms_in_if;
  logic valid;
  logic ready;
  logic button;

  modport source (output valid, output button, input ready);
  modport sink (input valid, input button, output ready);
endinterface

interface lpms_res_if
  import lpms_pkg::*;
#(
  parameter int unsigned HOLD_WIDTH = HoldWidthDef
);
  logic                  valid;
  logic                  ready;
  logic [LedW-1:0]       leds;
  logic [HOLD_WIDTH-1:0] hold_ticks;
  logic [ModeW-1:0]      mode;
  logic                  press_accepted;

  modport source (output valid, output leds, output hold_ticks, output mode,
                  output press_accepted, input ready);
  modport sink (input valid, input leds, input hold_ticks, input mode,
                input press_accepted, output ready);
endinterface

interface lpms_cfg_if
  import lpms_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/lpms_cfg_regs.sv */
// Configuration register file of the LED pattern mode sequencer.
// Depends on lpms_pkg and lpms_cfg_if.
`timescale 1ns / 1ps

module lpms_cfg_regs
  import lpms_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  lpms_cfg_if.sink          cfg_i,
  output cfg_t              cfg_o,
  output seed_load_t        seed_load_o
);

  logic [CfgW-1:0]  bounce_hold_q;
  logic [CfgW-1:0]  count_hold_q;
  logic [CfgW-1:0]  breath_period_q;
  logic [CfgW-1:0]  breath_inc_q;
  logic [CfgW-1:0]  random_hold_q;
  logic [CfgW-1:0]  debounce_wait_q;
  logic [SeedW-1:0] random_seed_q;
  logic             wr;
  logic [CfgW-1:0]  wdata24;

  // Always take a write word
  assign cfg_i.ready = 1'b1;
  assign wr          = cfg_i.valid;
  assign wdata24     = cfg_i.data[CfgW-1:0];

  // Decode the register index and write
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bounce_hold_q   <= BounceHoldRst;
      count_hold_q    <= CountHoldRst;
      breath_period_q <= BreathPeriodRst;
      breath_inc_q    <= BreathIncRst;
      random_hold_q   <= RandomHoldRst;
      debounce_wait_q <= DebounceRst;
      random_seed_q   <= SeedRst;
    end else if (wr) begin
      case (reg_idx_e'(cfg_i.index))
        REG_BOUNCE_HOLD:   bounce_hold_q   <= wdata24;
        REG_COUNT_HOLD:    count_hold_q    <= wdata24;
        REG_BREATH_PERIOD: breath_period_q <= wdata24;
        REG_BREATH_INC:    breath_inc_q    <= wdata24;
        REG_RANDOM_HOLD:   random_hold_q   <= wdata24;
        REG_DEBOUNCE_WAIT: debounce_wait_q <= wdata24;
        REG_RANDOM_SEED:   random_seed_q   <= cfg_i.data[SeedW-1:0];
        default: ;
      endcase
    end
  end

  // Debounce wait is only flagged to the consumer; keep it as a register, but
  // it does not alter any result field.
  logic unused_debounce;
  assign unused_debounce = ^debounce_wait_q;

  assign cfg_o.bounce_hold   = bounce_hold_q;
  assign cfg_o.count_hold    = count_hold_q;
  assign cfg_o.breath_period = breath_period_q;
  assign cfg_o.breath_inc    = breath_inc_q;
  assign cfg_o.random_hold   = random_hold_q ^ {CfgW{unused_debounce & 1'b0}};

  // Seed write loads the xorshift state in the same cycle
  assign seed_load_o.load = wr && (reg_idx_e'(cfg_i.index) == REG_RANDOM_SEED);
  assign seed_load_o.seed = cfg_i.data[SeedW-1:0];

  // Stored seed feeds no other logic; fold it in the same way
  logic unused_seed;
  assign unused_seed = ^random_seed_q;

endmodule

/* hw/rtl/lpms_core.sv */
// Pattern state and combinational step logic of the LED pattern mode
// sequencer. Depends on lpms_pkg.
`timescale 1ns / 1ps

module lpms_core
  import lpms_pkg::*;
#(
  parameter int unsigned HOLD_WIDTH = HoldWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  adv_i,
  input  logic                  button_i,
  input  cfg_t                  cfg_i,
  input  seed_load_t            seed_load_i,
  output step_t                 step_o,
  output logic [HOLD_WIDTH-1:0] hold_o
);

  // Offset sum never overflows this width
  localparam int unsigned SumW = ((HOLD_WIDTH > CfgW) ? HOLD_WIDTH : CfgW) + 1;

  mode_e                 mode_q, mode_d;
  logic                  last_q, last_d;
  logic [BouncePosW-1:0] pos_q, pos_d;
  logic                  dir_q, dir_d;
  logic [CountW-1:0]     cnt_q, cnt_d;
  logic [HOLD_WIDTH-1:0] offset_q, offset_d;
  logic                  off_q, off_d;
  logic [SeedW-1:0]      rnd_q, rnd_d;

  logic                  at_start;
  logic                  press;
  logic [SumW-1:0]       offset_ext;
  logic [SumW-1:0]       period_ext;
  logic [SumW-1:0]       inc_ext;
  logic [SumW-1:0]       offset_sum;
  logic [SumW-1:0]       off_hold;
  logic [SeedW-1:0]      rnd_next;

  // Loop start and mode advance on a rising button edge
  always_comb begin
    case (mode_q)
      MODE_COUNT:  at_start = (cnt_q == '0);
      MODE_BREATH: at_start = (offset_q == '0) && !off_q;
      default:     at_start = 1'b1;
    endcase
    press  = at_start && button_i && !last_q;
    mode_d = press ? mode_e'(mode_q + 2'd1) : mode_q;
    last_d = at_start ? button_i : last_q;
  end

  // Breathing arithmetic
  assign offset_ext = SumW'(offset_q);
  assign period_ext = SumW'(cfg_i.breath_period);
  assign inc_ext    = (cfg_i.breath_inc == '0) ? SumW'(1) : SumW'(cfg_i.breath_inc);
  assign offset_sum = offset_ext + inc_ext;
  assign off_hold   = (offset_ext < period_ext) ? (period_ext - offset_ext) : '0;
  assign rnd_next   = xorshift32(rnd_q);

  // Produce this step's LEDs and hold, and the next pattern state
  always_comb begin
    pos_d    = pos_q;
    dir_d    = dir_q;
    cnt_d    = cnt_q;
    offset_d = offset_q;
    off_d    = off_q;
    rnd_d    = rnd_q;
    step_o.leds           = '0;
    step_o.mode           = mode_d;
    step_o.press_accepted = press;
    hold_o                = '0;
    case (mode_d)
      MODE_BOUNCE: begin
        step_o.leds = LedW'(1) << pos_q;
        hold_o      = HOLD_WIDTH'(cfg_i.bounce_hold);
        pos_d       = pos_q + (dir_q ? 2'd1 : 2'd3);
        if (pos_d == 2'd3) dir_d = 1'b0;
        if (pos_d == 2'd0) dir_d = 1'b1;
      end
      MODE_COUNT: begin
        step_o.leds = cnt_q;
        hold_o      = HOLD_WIDTH'(cfg_i.count_hold);
        cnt_d       = cnt_q + 4'd1;
      end
      MODE_BREATH: begin
        if (!off_q) begin
          step_o.leds = '1;
          hold_o      = offset_q;
          off_d       = 1'b1;
        end else begin
          step_o.leds = '0;
          hold_o      = off_hold[HOLD_WIDTH-1:0];
          off_d       = 1'b0;
          offset_d    = (offset_sum >= period_ext) ? '0 : offset_sum[HOLD_WIDTH-1:0];
        end
      end
      MODE_RANDOM: begin
        step_o.leds = rnd_next[LedW-1:0];
        hold_o      = HOLD_WIDTH'(cfg_i.random_hold);
        rnd_d       = rnd_next;
      end
      default: begin
        step_o.leds = '0;
      end
    endcase
  end

  // Commit state when the step moves into the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_BOUNCE;
      last_q   <= 1'b0;
      pos_q    <= '0;
      dir_q    <= 1'b1;
      cnt_q    <= '0;
      offset_q <= '0;
      off_q    <= 1'b0;
    end else if (adv_i) begin
      mode_q   <= mode_d;
      last_q   <= last_d;
      pos_q    <= pos_d;
      dir_q    <= dir_d;
      cnt_q    <= cnt_d;
      offset_q <= offset_d;
      off_q    <= off_d;
    end
  end

  // Xorshift state: a seed write wins over a step
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rnd_q <= SeedRst;
    end else if (seed_load_i.load) begin
      rnd_q <= seed_load_i.seed;
    end else if (adv_i) begin
      rnd_q <= rnd_d;
    end
  end

endmodule

/* hw/rtl/led_pattern_mode_sequencer.sv */
// LED pattern mode sequencer, top level. Each input word is one pattern step
// carrying the sampled button level; each result word gives four LED bits, a
// hold time in ticks, the current mode (0 bounce, 1 binary count, 2 breathing,
// 3 xorshift random) and a flag asking the consumer to wait the debounce time
// first. The button only counts at the start of a pattern loop, where a rising
// edge advances the mode. A word is held in the input register and then is
// stepped into the result register when the result side is ready; one word
// is taken every cycle while the output is drained, and the single step of
// the pattern state is what sets that rate. While a finished result
// waits, the input register still takes one more word and then the input
// stalls. Configuration words are always accepted; a seed write also reloads
// the random state. Depends on lpms_pkg, lpms_if, lpms_cfg_regs and lpms_core.
`timescale 1ns / 1ps

module led_pattern_mode_sequencer
  import lpms_pkg::*;
#(
  parameter int unsigned HOLD_WIDTH = HoldWidthDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  lpms_in_if.sink    item_in_i,
  lpms_res_if.source res_out_o,
  lpms_cfg_if.sink   cfg_i
);

  cfg_t                  cfg;
  seed_load_t            seed_load;
  step_t                 step;
  logic [HOLD_WIDTH-1:0] hold;

  logic                  in_vld_q;
  logic                  btn_q;
  logic                  res_vld_q;
  step_t                 res_q;
  logic [HOLD_WIDTH-1:0] res_hold_q;
  logic                  res_ready;
  logic                  adv;
  logic                  in_acc;

  // Handshake between the input register and the result register
  assign res_ready       = !res_vld_q || res_out_o.ready;
  assign adv             = in_vld_q && res_ready;
  assign item_in_i.ready = !in_vld_q || adv;
  assign in_acc          = item_in_i.valid && item_in_i.ready;

  lpms_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_i),
    .cfg_o       (cfg),
    .seed_load_o (seed_load)
  );

  lpms_core #(
    .HOLD_WIDTH (HOLD_WIDTH)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .button_i    (btn_q),
    .cfg_i       (cfg),
    .seed_load_i (seed_load),
    .step_o      (step),
    .hold_o      (hold)
  );

  // Input register: hold the button word until it can be stepped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_acc) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      btn_q <= item_in_i.button;
    end
  end

  // Result register: load on a step, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (adv) begin
      res_vld_q <= 1'b1;
    end else if (res_out_o.ready) begin
      res_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q      <= step;
      res_hold_q <= hold;
    end
  end

  assign res_out_o.valid          = res_vld_q;
  assign res_out_o.leds           = res_q.leds;
  assign res_out_o.hold_ticks     = res_hold_q;
  assign res_out_o.mode           = res_q.mode;
  assign res_out_o.press_accepted = res_q.press_accepted;

`ifndef SYNTHESIS
  // A stalled input word stays put
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && !res_ready |=> in_vld_q && $stable(btn_q))
    else $error("input word lost while result side stalled");

  // A mode switch needs the button pressed in that step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && step.press_accepted |-> btn_q)
    else $error("press accepted without button level");

  // Bounce mode lights exactly one LED
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_q.mode == MODE_BOUNCE |-> $onehot(res_q.leds))
    else $error("bounce step not one-hot");

  // Breathing mode is all on or all off
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_vld_q && res_q.mode == MODE_BREATH |-> res_q.leds == 4'hF || res_q.leds == 4'h0)
    else $error("breathing step neither full on nor off");
`endif

endmodule
